// ===== hw/rtl/pidtip_pkg.sv =====
// Shared types, codes and helpers for the turn-in-place PID step.
package pidtip_pkg;

  localparam int MagW     = 56;   // widest term magnitude (gain times operand)
  localparam int GainW    = 16;
  localparam int DivW     = 16;
  localparam int PowerW   = 48;
  localparam int QuotW    = 47;
  localparam int CntW     = 6;
  localparam int MulSteps = GainW;
  localparam int DivSteps = MagW;

  localparam logic [15:0] IntDivisor = 16'd3125;
  localparam logic [15:0] BandLimit  = 16'd50;
  localparam logic [15:0] SettleMs   = 16'd100;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_INIT_DIFF = 3'd1,
    REG_GAIN_P    = 3'd2,
    REG_GAIN_I    = 3'd3,
    REG_GAIN_D    = 3'd4,
    REG_FF        = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_PREP = 3'd1,
    S_UPD  = 3'd2,
    S_LOAD = 3'd3,
    S_MUL  = 3'd4,
    S_DIV  = 3'd5,
    S_ACC  = 3'd6,
    S_FIN  = 3'd7
  } state_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic [15:0]        time_ms;
    logic               first_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_power;
    logic signed [15:0] right_power;
    logic               settled;
  } out_t;

  typedef struct packed {
    logic  load_in;
    logic  prep;
    logic  update;
    logic  term_load;
    term_t term;
    logic  mul_step;
    logic  div_step;
    logic  acc;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic dt_zero;
    logic mul_last;
    logic div_last;
    logic out_busy;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
    if (v > 49'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -49'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// ===== hw/rtl/pidtip_ctrl.sv =====
// Sequencer for the PID step: walks the shared multiply/divide unit over the three terms.
module pidtip_ctrl import pidtip_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  term_t  term, term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= TERM_P;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    cmd.term   = term;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // a settled turn answers at once and holds its state
        if (status.skip) begin
          state_next = S_FIN;
        end else begin
          cmd.update = 1'b1;
          term_next  = TERM_P;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.term_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        case (term)
          TERM_P: begin
            term_next  = TERM_I;
            state_next = S_LOAD;
          end
          TERM_I: begin
            // no derivative when no time has passed
            if (status.dt_zero) begin
              state_next = S_FIN;
            end else begin
              term_next  = TERM_D;
              state_next = S_LOAD;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_PREP)
    else $error("accepted request did not start preparation");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !status.out_busy |=> state == S_IDLE)
    else $error("result load did not return to idle");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_step && cmd.div_step))
    else $error("multiply and divide step issued together");

  a_term_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> (term == TERM_P || term == TERM_I || term == TERM_D))
    else $error("term index out of range while multiplying");
`endif

endmodule

// ===== hw/rtl/pidtip_dp.sv =====
// Datapath: configuration, loop state, shift-add multiplier, restoring divider, output register.
module pidtip_dp import pidtip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  in_t         in_data,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  logic signed [15:0] target_angle;
  logic [14:0]        initial_difference;
  logic [15:0]        gain_p, gain_i, gain_d;
  logic [14:0]        feedforward;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle       <= '0;
      initial_difference <= 15'd18000;
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      feedforward        <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_TARGET:    target_angle       <= cfg_wdata;
        REG_INIT_DIFF: initial_difference <= cfg_wdata[14:0];
        REG_GAIN_P:    gain_p             <= cfg_wdata;
        REG_GAIN_I:    gain_i             <= cfg_wdata;
        REG_GAIN_D:    gain_d             <= cfg_wdata;
        REG_FF:        feedforward        <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // loop state
  logic signed [15:0] prev_err;
  logic [15:0]        prev_time;
  logic signed [39:0] isum;
  logic               in_band;
  logic [15:0]        band_entry;
  logic               done;

  // sample registers
  in_t                smp;
  logic signed [15:0] e_reg, pe_reg;
  logic [15:0]        dt_reg;
  logic signed [33:0] iprod;
  logic               skip;

  // wrap heading - target to [-18000, 18000)
  logic signed [16:0] diff;
  logic [18:0]        m0, m1;
  logic signed [15:0] e_comb;
  always_comb begin
    diff = 17'(smp.heading) - 17'(target_angle);
    m0   = 19'(signed'(diff) + 19'sd72000);
    if (m0 >= 19'd108000)     m1 = m0 - 19'd108000;
    else if (m0 >= 19'd72000) m1 = m0 - 19'd72000;
    else if (m0 >= 19'd36000) m1 = m0 - 19'd36000;
    else                      m1 = m0;
    e_comb = (m1 >= 19'd18000) ? 16'(m1 - 19'd36000) : m1[15:0];
  end

  logic signed [15:0] pe_comb;
  logic [15:0]        dt_comb;
  logic signed [16:0] esum;
  assign pe_comb = smp.first_sample ? e_comb : prev_err;
  assign dt_comb = smp.time_ms - (smp.first_sample ? 16'd0 : prev_time);
  assign esum    = 17'(e_comb) + 17'(pe_comb);

  // integral update with saturation
  logic signed [40:0] isum_add;
  logic signed [39:0] isum_sat;
  always_comb begin
    isum_add = (smp.first_sample ? 41'sd0 : 41'(isum)) + 41'(iprod);
    if (isum_add > 41'sh7f_ffff_ffff)       isum_sat = 40'sh7f_ffff_ffff;
    else if (isum_add < -41'sh80_0000_0000) isum_sat = 40'sh80_0000_0000;
    else                                    isum_sat = isum_add[39:0];
  end

  logic        band_now, band_was;
  logic [15:0] band_age;
  assign band_now = (e_reg < signed'(BandLimit)) && (e_reg > -signed'(BandLimit));
  assign band_was = smp.first_sample ? 1'b0 : in_band;
  assign band_age = smp.time_ms - band_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err   <= '0;
      prev_time  <= '0;
      isum       <= '0;
      in_band    <= 1'b0;
      band_entry <= '0;
      done       <= 1'b0;
    end else if (cmd.update) begin
      isum      <= isum_sat;
      prev_time <= smp.time_ms;
      prev_err  <= e_reg;
      done      <= smp.first_sample ? 1'b0 : done;
      if (band_now) begin
        in_band <= 1'b1;
        if (!band_was) begin
          band_entry <= smp.time_ms;
        end else if (band_age >= SettleMs) begin
          done <= 1'b1;
        end
      end else begin
        in_band <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) smp <= in_data;
    if (cmd.prep) begin
      e_reg  <= e_comb;
      pe_reg <= pe_comb;
      dt_reg <= dt_comb;
      iprod  <= 34'(esum) * signed'({1'b0, dt_comb});
      skip   <= done && !smp.first_sample;
    end
  end

  // term operands
  logic [15:0]        e_mag;
  logic signed [40:0] isum_ext;
  logic [40:0]        isum_mag;
  logic signed [16:0] de;
  logic [16:0]        de_mag;
  logic [MagW-1:0]    mag_sel;
  logic [GainW-1:0]   gain_sel;
  logic [DivW-1:0]    div_sel;
  logic               sgn_sel;
  always_comb begin
    e_mag    = e_reg[15] ? 16'(-e_reg) : e_reg;
    isum_ext = 41'(isum);
    isum_mag = isum_ext[40] ? 41'(-isum_ext) : isum_ext;
    de       = 17'(e_reg) - 17'(pe_reg);
    de_mag   = de[16] ? 17'(-de) : de;
    case (cmd.term)
      TERM_P: begin
        mag_sel  = MagW'(e_mag) << 7;
        gain_sel = gain_p;
        div_sel  = (initial_difference == '0) ? DivW'(1) : DivW'(initial_difference);
        sgn_sel  = e_reg[15];
      end
      TERM_I: begin
        mag_sel  = MagW'(isum_mag) << 1;
        gain_sel = gain_i;
        div_sel  = IntDivisor;
        sgn_sel  = isum[39];
      end
      default: begin
        mag_sel  = (MagW'(de_mag) << 10) + (MagW'(de_mag) << 8);
        gain_sel = gain_d;
        div_sel  = dt_reg;
        sgn_sel  = de[16];
      end
    endcase
  end

  // shared shift-add multiplier, then restoring divider on the same accumulator
  logic [MagW-1:0]  mag, acc;
  logic [GainW-1:0] gsh;
  logic [DivW-1:0]  divr, rem;
  logic             sgn;
  logic [CntW-1:0]  cnt;
  logic [DivW:0]    trial;
  logic             fits;
  logic             mul_last, div_last;

  assign mul_last = (cnt == CntW'(MulSteps - 1));
  assign div_last = (cnt == CntW'(DivSteps - 1));
  assign trial    = {rem, acc[MagW-1]};
  assign fits     = trial >= {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.term_load) begin
      cnt <= '0;
    end else if (cmd.mul_step) begin
      cnt <= mul_last ? '0 : cnt + 1'b1;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term_load) begin
      mag  <= mag_sel;
      gsh  <= gain_sel;
      divr <= div_sel;
      sgn  <= sgn_sel;
      acc  <= '0;
      rem  <= '0;
    end else if (cmd.mul_step) begin
      acc <= (acc << 1) + (gsh[GainW-1] ? mag : '0);
      gsh <= gsh << 1;
    end else if (cmd.div_step) begin
      rem <= fits ? DivW'(trial - {1'b0, divr}) : trial[DivW-1:0];
      acc <= {acc[MagW-2:0], fits};
    end
  end

  logic signed [PowerW-1:0] power, term_val;
  assign term_val = sgn ? -PowerW'(acc[QuotW-1:0]) : PowerW'(acc[QuotW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.update)   power <= '0;
    else if (cmd.acc) power <= power + term_val;
  end

  // wheel drive with feedforward pushed along the power
  logic signed [48:0] p49, ff49, l49, r49;
  always_comb begin
    p49  = 49'(power);
    ff49 = 49'(signed'({1'b0, feedforward}));
    if (p49 > 49'sd0) begin
      r49 = p49 + ff49;
      l49 = -r49;
    end else begin
      l49 = ff49 - p49;
      r49 = p49 - ff49;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.left_power  <= done ? 16'sd0 : sat16(l49);
      out_data.right_power <= done ? 16'sd0 : sat16(r49);
      out_data.settled     <= done;
    end
  end

  assign status.skip     = skip;
  assign status.dt_zero  = (dt_reg == '0);
  assign status.mul_last = mul_last;
  assign status.div_last = div_last;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== hw/rtl/pid_turn_in_place_step_top.sv =====
// Top level of the turn-in-place PID step: sequencer plus datapath.
//
// Input channel in_valid/in_ready/in_data carries one heading request: the
// heading in centidegrees, a millisecond time stamp and a first-sample flag
// that starts a new turn. Output channel out_valid/out_ready/out_data returns
// one result per request: left and right wheel drive in Q1.15 and a settled
// flag. The user must write registers through cfg_wr_en/cfg_addr/cfg_wdata
// only while idle; the block itself does not enforce this.
// A request runs from acceptance through error, time step and integral
// update, then three terms on one shared unit (load, 16 shift-add steps by
// the gain, 56 restoring divide steps, accumulate), then the wheel mix into
// the output register. The derivative term is left out when no time has
// passed, and a settled turn skips the terms and answers at once. The next
// request can be taken in the same cycle as the result appears in the
// output register, but none while one is in progress; a stalled receiver
// holds that register and the block waits before loading the following
// result. Reset (rst, synchronous) clears the loop state and restores
// default registers; it takes effect on the next edge.
module pid_turn_in_place_step_top import pidtip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  cmd_t    cmd;
  status_t status;

  pidtip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pidtip_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
